@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the scanout converter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define VSPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// condition in one cycle implies a result in the next
`define VSPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/vspc_pkg.sv @@
// ----------------------------------------------------------------------------
// vspc_pkg
// shared types, constants and helpers of the scanout pixel converter
// ----------------------------------------------------------------------------
package vspc_pkg;

    localparam int VRAM_WIDTH_DEF  = 1024;
    localparam int VRAM_HEIGHT_DEF = 512;

    // field widths of the register and data ports
    localparam int DISP_W_W   = 11;
    localparam int DISP_H_W   = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int WORD_W     = 16;
    localparam int COLOR_W    = 8;

    // register reset values
    localparam int RESET_WIDTH  = 320;
    localparam int RESET_HEIGHT = 240;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DISPLAY_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE_24BIT     = 2'd2;

    // bytes held toward the next 24-bit pixel
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // non-black counter saturates here; threshold compare uses count * 20
    localparam int CNT_W     = 20;
    localparam int CNT_X20_W = CNT_W + 5;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam int CONTENT_RATIO = 20;

    typedef struct packed {
        logic fire;      // a pixel is produced
        logic nonblack;  // that pixel is not black
        logic clear;     // frame end or register write
    } pix_evt_t;

    function automatic logic [COLOR_W-1:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

@@ src/vspc_content.sv @@
// ----------------------------------------------------------------------------
// vspc_content
// non-black pixel counter and frame content threshold compare
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vspc_content #(
    parameter int AREA_W = 21
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  vspc_pkg::pix_evt_t  evt,
    input  logic [AREA_W-1:0]   area,
    output logic                content
);
    import vspc_pkg::*;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_X20_W-1:0] x20_reg;
    logic [CNT_X20_W-1:0] x20_next;
    logic                 inc;

    assign inc = evt.fire && evt.nonblack && (count_reg != COUNT_MAX);

    // count > area/20 is the same as area < 20 * count
    always_comb begin
        count_next = inc ? count_reg + 1'b1 : count_reg;
        x20_next   = inc ? x20_reg + CNT_X20_W'(CONTENT_RATIO) : x20_reg;
        content    = CNT_X20_W'(area) < x20_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            x20_reg   <= '0;
        end else if (evt.clear) begin
            count_reg <= '0;
            x20_reg   <= '0;
        end else begin
            count_reg <= count_next;
            x20_reg   <= x20_next;
        end
    end

    `VSPC_ASSERT(a_x20_track, aclk, aresetn,
        x20_reg == ({5'd0, count_reg} << 4) + ({5'd0, count_reg} << 2),
        "scaled count lost track of the pixel count")
    `VSPC_ASSERT_NEXT(a_clear, aclk, aresetn, evt.clear, count_reg == '0,
        "count not cleared at frame end")
    `VSPC_ASSERT_NEXT(a_monotonic, aclk, aresetn, !evt.clear,
        count_reg >= $past(count_reg), "count went down without a clear")

endmodule

@@ src/vram_scanout_pixel_converter_core.sv @@
// ----------------------------------------------------------------------------
// vram_scanout_pixel_converter_core
// frame-buffer words (15-bit or byte-packed 24-bit) to rgb888 pixels
// ----------------------------------------------------------------------------
// each word sits in the input register, its pixel then in the result register
// throughput: one word per cycle, set by the single-pass convert logic, while
//   the result register is not held by m_ready back-pressure
// reset: 320x240, 15-bit mode, all positions, held bytes and the count cleared;
//   a write to the width, height or mode register restarts the frame
`include "assert_macros.svh"

module vram_scanout_pixel_converter_core #(
    parameter int VRAM_WIDTH  = vspc_pkg::VRAM_WIDTH_DEF,
    parameter int VRAM_HEIGHT = vspc_pkg::VRAM_HEIGHT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vspc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [vspc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // frame-buffer words
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [vspc_pkg::WORD_W-1:0]      s_vram_word,
    // pixels
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [vspc_pkg::COLOR_W-1:0]     m_red,
    output logic [vspc_pkg::COLOR_W-1:0]     m_green,
    output logic [vspc_pkg::COLOR_W-1:0]     m_blue,
    output logic                             m_frame_last,
    output logic                             m_has_content
);
    import vspc_pkg::*;

    localparam int MAX_W   = (VRAM_WIDTH  < 2047) ? VRAM_WIDTH  : 2047;
    localparam int MAX_H   = (VRAM_HEIGHT < 1023) ? VRAM_HEIGHT : 1023;
    localparam int COL_W   = $clog2(MAX_W + 1);
    localparam int ROW_W   = $clog2(MAX_H + 1);
    localparam int MAX_WPR = (3 * MAX_W + 1) / 2;
    localparam int WIR_W   = $clog2(MAX_WPR + 1);
    localparam int AREA_W  = COL_W + ROW_W;
    localparam int RST_W   = (RESET_WIDTH  > MAX_W) ? MAX_W : RESET_WIDTH;
    localparam int RST_H   = (RESET_HEIGHT > MAX_H) ? MAX_H : RESET_HEIGHT;

    // configuration, stored already clamped
    logic [COL_W-1:0]   eff_w_reg, eff_w_next;
    logic [ROW_W-1:0]   eff_h_reg, eff_h_next;
    logic               mode_reg, mode_next;
    logic               cfg_restart;
    logic [DISP_W_W-1:0] w_in;
    logic [DISP_H_W-1:0] h_in;
    logic [COL_W+1:0]   wpr_x2;
    logic [WIR_W-1:0]   wpr_reg;
    logic [AREA_W-1:0]  area_reg;

    // input register
    logic               in_v_reg;
    logic [WORD_W-1:0]  word_reg;

    // scan state
    logic [WORD_W-1:0]  byte_hold_reg, byte_hold_next;
    logic [1:0]         held_reg, held_next;
    logic [WIR_W-1:0]   wir_reg, wir_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    // result register
    logic               m_valid_reg;
    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg;
    logic               last_reg, content_reg;

    logic [COLOR_W-1:0] r, g, b;
    logic [COLOR_W-1:0] lo, hi;
    logic               pix, have, last, row_end, frame_end, proc, content;
    pix_evt_t           evt;

    assign cfg_ready = 1'b1;
    assign w_in      = cfg_wdata[DISP_W_W-1:0];
    assign h_in      = cfg_wdata[DISP_H_W-1:0];

    always_comb begin
        eff_w_next  = eff_w_reg;
        eff_h_next  = eff_h_reg;
        mode_next   = mode_reg;
        cfg_restart = 1'b0;
        if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_DISPLAY_WIDTH: begin
                    if (w_in == '0) begin
                        eff_w_next = COL_W'(1);
                    end else if (w_in > DISP_W_W'(MAX_W)) begin
                        eff_w_next = COL_W'(MAX_W);
                    end else begin
                        eff_w_next = w_in[COL_W-1:0];
                    end
                    cfg_restart = 1'b1;
                end
                REG_DISPLAY_HEIGHT: begin
                    if (h_in == '0) begin
                        eff_h_next = ROW_W'(1);
                    end else if (h_in > DISP_H_W'(MAX_H)) begin
                        eff_h_next = ROW_W'(MAX_H);
                    end else begin
                        eff_h_next = h_in[ROW_W-1:0];
                    end
                    cfg_restart = 1'b1;
                end
                REG_MODE_24BIT: begin
                    mode_next   = cfg_wdata[0];
                    cfg_restart = 1'b1;
                end
                default: begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    // 3w + 1, halved below for the 24-bit words per row
    assign wpr_x2 = {1'b0, eff_w_reg, 1'b0} + {2'b00, eff_w_reg} + (COL_W+2)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg <= COL_W'(RST_W);
            eff_h_reg <= ROW_W'(RST_H);
            mode_reg  <= 1'b0;
        end else begin
            eff_w_reg <= eff_w_next;
            eff_h_reg <= eff_h_next;
            mode_reg  <= mode_next;
        end
    end

    // derived frame geometry, registered from the configuration registers in the next cycle
    always_ff @(posedge aclk) begin
        wpr_reg  <= mode_reg ? WIR_W'(wpr_x2[COL_W+1:1]) : WIR_W'(eff_w_reg);
        area_reg <= {{ROW_W{1'b0}}, eff_w_reg} * {{COL_W{1'b0}}, eff_h_reg};
    end

    // convert the word in the input register
    assign lo = word_reg[7:0];
    assign hi = word_reg[15:8];

    always_comb begin
        byte_hold_next = byte_hold_reg;
        held_next      = held_reg;
        r   = '0;
        g   = '0;
        b   = '0;
        pix = 1'b0;
        if (!mode_reg) begin
            r   = widen5(word_reg[4:0]);
            g   = widen5(word_reg[9:5]);
            b   = widen5(word_reg[14:10]);
            pix = 1'b1;
        end else begin
            case (held_reg)
                HELD_TWO: begin
                    r = byte_hold_reg[7:0];
                    g = byte_hold_reg[15:8];
                    b = lo;
                    byte_hold_next = {8'd0, hi};
                    held_next      = HELD_ONE;
                    pix            = 1'b1;
                end
                HELD_ONE: begin
                    r = byte_hold_reg[7:0];
                    g = lo;
                    b = hi;
                    byte_hold_next = '0;
                    held_next      = HELD_NONE;
                    pix            = 1'b1;
                end
                default: begin
                    byte_hold_next = word_reg;
                    held_next      = HELD_TWO;
                end
            endcase
        end

        // bytes past the row's last pixel are dropped
        have      = pix && (col_reg < eff_w_reg);
        row_end   = ({1'b0, wir_reg} + 1'b1) >= {1'b0, wpr_reg};
        frame_end = row_end && (({1'b0, row_reg} + 1'b1) >= {1'b0, eff_h_reg});
        last      = have && (({1'b0, col_reg} + 1'b1) == {1'b0, eff_w_reg})
                    && (({1'b0, row_reg} + 1'b1) >= {1'b0, eff_h_reg});

        col_next = have ? col_reg + 1'b1 : col_reg;
        wir_next = wir_reg + 1'b1;
        row_next = row_reg;
        if (row_end) begin
            wir_next       = '0;
            col_next       = '0;
            byte_hold_next = '0;
            held_next      = HELD_NONE;
            row_next       = frame_end ? '0 : row_reg + 1'b1;
        end
    end

    // a word that yields no pixel never waits on the result side
    assign proc    = in_v_reg && (!have || !m_valid_reg || m_ready);
    assign s_ready = !in_v_reg || proc;

    assign evt.fire     = proc && have;
    assign evt.nonblack = (r | g | b) != '0;
    assign evt.clear    = (proc && frame_end) || cfg_restart;

    vspc_content #(
        .AREA_W (AREA_W)
    ) u_content (
        .aclk    (aclk),
        .aresetn (aresetn),
        .evt     (evt),
        .area    (area_reg),
        .content (content)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_ready) begin
            in_v_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            word_reg <= s_vram_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_restart) begin
            byte_hold_reg <= '0;
            held_reg      <= HELD_NONE;
            wir_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
        end else if (proc) begin
            byte_hold_reg <= byte_hold_next;
            held_reg      <= held_next;
            wir_reg       <= wir_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc && have) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (proc && have) begin
            red_reg     <= r;
            green_reg   <= g;
            blue_reg    <= b;
            last_reg    <= last;
            content_reg <= last && content;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red         = red_reg;
    assign m_green       = green_reg;
    assign m_blue        = blue_reg;
    assign m_frame_last  = last_reg;
    assign m_has_content = content_reg;

    `VSPC_ASSERT(a_content_on_last, aclk, aresetn,
        !(m_valid_reg && content_reg) || last_reg,
        "content flag outside the frame's last pixel")
    `VSPC_ASSERT(a_no_hold_15bit, aclk, aresetn, mode_reg || held_reg == HELD_NONE,
        "bytes held while in 15-bit mode")
    `VSPC_ASSERT(a_col_in_row, aclk, aresetn, col_reg <= eff_w_reg,
        "pixel column ran past the row width")
    `VSPC_ASSERT_NEXT(a_cfg_restart, aclk, aresetn, cfg_restart,
        col_reg == '0 && row_reg == '0 && wir_reg == '0 && held_reg == HELD_NONE,
        "register write did not restart the frame")

endmodule
